### rtl/velocity_heatmap_pixel_assert.svh
// Assertion macros for the heat-map pixel pipeline.
// Each macro expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef VELOCITY_HEATMAP_PIXEL_ASSERT_SVH
`define VELOCITY_HEATMAP_PIXEL_ASSERT_SVH

// Same-cycle implication.
`define VHP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define VHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/vhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vhp_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int HALF_Q15    = 16384;
    localparam int ONE_Q15     = 32768;

    // Square root: 16 result bits, SQRT_STEPS bits per pipeline stage.
    localparam int SQRT_STEPS  = 4;
    localparam int SQRT_STAGES = 4;

    // Pipeline: square, sum, 4 x sqrt, gain, weights, products, saturate.
    localparam int NUM_STAGES  = 10;

    localparam logic [23:0] RST_COLOR_LOW  = 24'h190000;
    localparam logic [23:0] RST_COLOR_MID  = 24'hFF1414;
    localparam logic [23:0] RST_COLOR_HIGH = 24'hFF6432;
    localparam logic [7:0]  RST_SPEED_GAIN = 8'd10;
    localparam logic [12:0] RST_FRAME_W    = 13'd512;

    typedef enum logic [2:0] {
        CFG_COLOR_LOW  = 3'd0,
        CFG_COLOR_MID  = 3'd1,
        CFG_COLOR_HIGH = 3'd2,
        CFG_SPEED_GAIN = 3'd3,
        CFG_FRAME_W    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic [11:0]        pos_x;
        logic [11:0]        pos_y;
    } t_in_beat;

    typedef struct packed {
        logic [25:0] byte_offset;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_out_beat;

    // Working set of one square-root stage.
    typedef struct packed {
        logic [31:0] rad;     // radicand bits not yet consumed, MSB first
        logic [15:0] root;
        logic [16:0] rem;
        logic [25:0] offset;
    } t_sqrt_st;

    typedef struct packed {
        logic [23:0] low;
        logic [23:0] mid;
        logic [23:0] high;
    } t_grad_cfg;

endpackage

`default_nettype wire

### rtl/vhp_sqrt_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module vhp_sqrt_stage (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_en,
    input  wire               i_valid,
    input  vhp_pkg::t_sqrt_st i_st,
    output logic              o_valid,
    output vhp_pkg::t_sqrt_st o_st
);
    import vhp_pkg::*;

    t_sqrt_st n_st;
    logic     r_valid;
    t_sqrt_st r_st;

    // Restoring digit-by-digit root, SQRT_STEPS result bits.
    always_comb begin
        logic [18:0] rem_s;
        logic [18:0] trial;
        logic [31:0] rad;
        logic [15:0] root;
        logic [16:0] rem;
        rad  = i_st.rad;
        root = i_st.root;
        rem  = i_st.rem;
        for (int i = 0; i < SQRT_STEPS; i++) begin
            rem_s = {rem, rad[31:30]};
            trial = {1'b0, root, 2'b01};
            rad   = {rad[29:0], 2'b00};
            if (rem_s >= trial) begin
                rem_s = rem_s - trial;
                root  = {root[14:0], 1'b1};
            end else begin
                root  = {root[14:0], 1'b0};
            end
            rem = rem_s[16:0];
        end
        n_st        = i_st;
        n_st.rad    = rad;
        n_st.root   = root;
        n_st.rem    = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_valid;
    assign o_st    = r_st;

endmodule

`default_nettype wire

### rtl/vhp_blend.sv
`timescale 1ns / 1ps
`default_nettype none

module vhp_blend (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire  [2:0]         i_en,
    input  wire                i_valid,
    input  wire  [23:0]        i_t,
    input  wire  [25:0]        i_offset,
    input  vhp_pkg::t_grad_cfg i_grad,
    output logic [2:0]         o_valid,
    output vhp_pkg::t_out_beat o_data
);
    import vhp_pkg::*;

    // Stage A: segment select and weights
    logic               r_a_v;
    logic               r_a_sel;
    logic signed [24:0] r_a_w0;
    logic [23:0]        r_a_w1;
    logic [25:0]        r_a_off;

    // Stage B: per-channel products
    logic               r_b_v;
    logic signed [33:0] r_b_p0 [3];
    logic [31:0]        r_b_p1 [3];
    logic [25:0]        r_b_off;

    // Stage C: output register
    logic               r_c_v;
    t_out_beat          r_c_data;

    logic               n_sel;
    logic signed [24:0] n_w0;
    logic [23:0]        n_w1;
    logic signed [33:0] n_p0 [3];
    logic [31:0]        n_p1 [3];
    logic [7:0]         n_ch [3];

    always_comb begin
        n_sel = (i_t > 24'(HALF_Q15));
        if (n_sel) begin
            n_w0 = 25'(ONE_Q15) - signed'({1'b0, i_t});
            n_w1 = i_t - 24'(HALF_Q15);
        end else begin
            n_w0 = 25'(HALF_Q15) - signed'({1'b0, i_t});
            n_w1 = i_t;
        end
    end

    // Operands widened to the product width before the multiply.
    always_comb begin
        logic [7:0] p;
        logic [7:0] q;
        for (int c = 0; c < 3; c++) begin
            if (r_a_sel) begin
                p = i_grad.mid[8*(2-c) +: 8];
                q = i_grad.high[8*(2-c) +: 8];
            end else begin
                p = i_grad.low[8*(2-c) +: 8];
                q = i_grad.mid[8*(2-c) +: 8];
            end
            n_p0[c] = 34'(signed'({1'b0, p})) * 34'(r_a_w0);
            n_p1[c] = 32'(q) * 32'(r_a_w1);
        end
    end

    // Sum, then floor at zero and clamp at 255 (>= 2^22 before the shift).
    always_comb begin
        logic signed [33:0] n;
        for (int c = 0; c < 3; c++) begin
            n = r_b_p0[c] + signed'({2'b00, r_b_p1[c]});
            if (n[33]) begin
                n_ch[c] = 8'd0;
            end else if (n[32:22] != 11'd0) begin
                n_ch[c] = 8'd255;
            end else begin
                n_ch[c] = n[21:14];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (i_en[0]) begin
                r_a_v <= i_valid;
            end
            if (i_en[1]) begin
                r_b_v <= r_a_v;
            end
            if (i_en[2]) begin
                r_c_v <= r_b_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a_sel <= n_sel;
            r_a_w0  <= n_w0;
            r_a_w1  <= n_w1;
            r_a_off <= i_offset;
        end
        if (i_en[1]) begin
            for (int c = 0; c < 3; c++) begin
                r_b_p0[c] <= n_p0[c];
                r_b_p1[c] <= n_p1[c];
            end
            r_b_off <= r_a_off;
        end
        if (i_en[2]) begin
            r_c_data.byte_offset <= r_b_off;
            r_c_data.red         <= n_ch[0];
            r_c_data.green       <= n_ch[1];
            r_c_data.blue        <= n_ch[2];
        end
    end

    assign o_valid = {r_c_v, r_b_v, r_a_v};
    assign o_data  = r_c_data;

endmodule

`default_nettype wire

### rtl/velocity_heatmap_pixel.sv
// Velocity heat-map pixel pipeline.
// Input channel (i_in_valid / o_in_ready / i_in_data): one beat per grid cell,
// carrying the Q1.15 velocity pair and the pixel column and row.
// Output channel (o_out_valid / i_out_ready / o_out_data): one beat per input
// beat, in order, with the BGRA byte offset and the red, green, blue bytes.
// Config port (i_cfg_we / i_cfg_addr / i_cfg_data): single-cycle writes of the
// gradient stops, speed gain and frame width; write only while idle.
// Pipeline: ten register stages (square, sum, four 4-bit square-root stages,
// gain multiply, blend weights, blend products, saturate).
// Throughput: one beat per clock sustained while i_out_ready is high.
// Stall: each stage holds its beat while the next one is full and blocked,
// so empty stages keep filling while the output waits; input ready drops
// only when every stage is occupied.
// Reset: synchronous, active low; all stages empty and the registers take
// their default gradient, gain 10 and width 512.
`timescale 1ns / 1ps
`default_nettype none

module velocity_heatmap_pixel (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  vhp_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output vhp_pkg::t_out_beat o_out_data,
    input  wire                i_cfg_we,
    input  wire  [2:0]         i_cfg_addr,
    input  wire  [23:0]        i_cfg_data
);
    import vhp_pkg::*;

    // Configuration registers
    logic [23:0] r_color_low;
    logic [23:0] r_color_mid;
    logic [23:0] r_color_high;
    logic [7:0]  r_speed_gain;
    logic [12:0] r_frame_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_low  <= RST_COLOR_LOW;
            r_color_mid  <= RST_COLOR_MID;
            r_color_high <= RST_COLOR_HIGH;
            r_speed_gain <= RST_SPEED_GAIN;
            r_frame_w    <= RST_FRAME_W;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_COLOR_LOW:  r_color_low  <= i_cfg_data;
                CFG_COLOR_MID:  r_color_mid  <= i_cfg_data;
                CFG_COLOR_HIGH: r_color_high <= i_cfg_data;
                CFG_SPEED_GAIN: r_speed_gain <= i_cfg_data[7:0];
                CFG_FRAME_W:    r_frame_w    <= i_cfg_data[12:0];
                default: ;      // unmapped index: dropped
            endcase
        end
    end

    // Per-stage valid and advance. A stage loads when it is empty or
    // the stage after it loads this cycle.
    logic [NUM_STAGES-1:0] stage_v;
    logic [NUM_STAGES-1:0] stage_en;

    always_comb begin
        stage_en[NUM_STAGES-1] = !stage_v[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !stage_v[k] || stage_en[k+1];
        end
    end

    assign o_in_ready = stage_en[0];

    // Stage 1: squares and row product
    logic        r_s1_v;
    logic [30:0] r_s1_sqx;
    logic [30:0] r_s1_sqy;
    logic [23:0] r_s1_row;
    logic [11:0] r_s1_px;

    logic signed [31:0] n_sqx;
    logic signed [31:0] n_sqy;
    logic [12:0]        n_w_sat;
    logic [24:0]        n_row;

    always_comb begin
        n_sqx   = i_in_data.vel_x * i_in_data.vel_x;
        n_sqy   = i_in_data.vel_y * i_in_data.vel_y;
        // Width clamps at MAX_WIDTH; the 12-bit coordinates are not checked against the frame width.
        n_w_sat = (r_frame_w > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : r_frame_w;
        n_row   = 25'(i_in_data.pos_y) * 25'(n_w_sat);
    end

    // Stage 2: radicand and byte offset (wraps at 26 bits)
    logic     r_s2_v;
    t_sqrt_st r_s2_st;
    t_sqrt_st n_s2_st;

    always_comb begin
        n_s2_st.rad    = {1'b0, r_s1_sqx} + {1'b0, r_s1_sqy};
        n_s2_st.root   = '0;
        n_s2_st.rem    = '0;
        n_s2_st.offset = {r_s1_row, 2'b00} + {12'd0, r_s1_px, 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (stage_en[0]) begin
                r_s1_v <= i_in_valid;
            end
            if (stage_en[1]) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_s1_sqx <= n_sqx[30:0];
            r_s1_sqy <= n_sqy[30:0];
            r_s1_row <= n_row[23:0];
            r_s1_px  <= i_in_data.pos_x;
        end
        if (stage_en[1]) begin
            r_s2_st <= n_s2_st;
        end
    end

    // Stages 3..6: square root, four result bits per stage
    logic     sq_v  [SQRT_STAGES+1];
    t_sqrt_st sq_st [SQRT_STAGES+1];

    assign sq_v[0]  = r_s2_v;
    assign sq_st[0] = r_s2_st;

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
        vhp_sqrt_stage u_sqrt (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (stage_en[2+g]),
            .i_valid (sq_v[g]),
            .i_st    (sq_st[g]),
            .o_valid (sq_v[g+1]),
            .o_st    (sq_st[g+1])
        );
    end

    // Stage 7: gradient position t = speed * gain (Q9.15)
    logic        r_s7_v;
    logic [23:0] r_s7_t;
    logic [25:0] r_s7_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_v <= 1'b0;
        end else if (stage_en[6]) begin
            r_s7_v <= sq_v[SQRT_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[6]) begin
            r_s7_t   <= sq_st[SQRT_STAGES].root * r_speed_gain;
            r_s7_off <= sq_st[SQRT_STAGES].offset;
        end
    end

    // Stages 8..10: blend and saturate
    t_grad_cfg grad;
    logic [2:0] blend_v;

    assign grad.low  = r_color_low;
    assign grad.mid  = r_color_mid;
    assign grad.high = r_color_high;

    vhp_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (stage_en[9:7]),
        .i_valid  (r_s7_v),
        .i_t      (r_s7_t),
        .i_offset (r_s7_off),
        .i_grad   (grad),
        .o_valid  (blend_v),
        .o_data   (o_out_data)
    );

    always_comb begin
        stage_v[0] = r_s1_v;
        stage_v[1] = r_s2_v;
        for (int k = 0; k < SQRT_STAGES; k++) begin
            stage_v[2+k] = sq_v[k+1];
        end
        stage_v[6]   = r_s7_v;
        stage_v[9:7] = blend_v;
    end

    assign o_out_valid = stage_v[NUM_STAGES-1];

    // Checks
    `include "velocity_heatmap_pixel_assert.svh"

    // An empty output stage lets the whole chain advance.
    `VHP_ASSERT_NOW(a_empty_out_ready, !o_out_valid, o_in_ready, "ready low with empty output")
    // A taking receiver never blocks the input.
    `VHP_ASSERT_NOW(a_flow_ready, i_out_ready, o_in_ready, "ready low while output drains")
    // An accepted beat lands in the first stage.
    `VHP_ASSERT_NEXT(a_accept_lands, i_in_valid && o_in_ready, r_s1_v, "accepted beat lost")

endmodule

`default_nettype wire
